// ----- rtl/pfba_pkg.sv -----
package pfba_pkg;

    localparam int PFBA_NUM_FRAMES = 1024;
    localparam int WORD_BITS       = 32;
    localparam int PAGE_W          = 10;
    localparam int COUNT_W         = 11;

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [PAGE_W-1:0] page;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [PAGE_W-1:0]  page_out;
        logic [COUNT_W-1:0] used_count;
    } t_rsp;

    // Position of the most significant set bit, counted from the MSB.
    function automatic logic [4:0] first_free(input logic [WORD_BITS-1:0] avail);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (avail[i]) begin
                idx = 5'(WORD_BITS - 1 - i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/pfba_ram.sv -----
module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/page_frame_bitmap_allocator.sv -----
// Out of range and unused opcodes go from the idle state straight to the done state,
//   mark and free pass through the modify state first, and allocate scans the bitmap.
// The scan reads one 32-bit word per cycle, set by the bitmap RAM's single read port;
//   a new item is taken only in the idle state, after the last result is registered.
// Reset: synchronous, active low; count, frame total (1024) and handshakes clear at
//   once, per-word valid flags make the whole bitmap read as free with no clear pass.
module page_frame_bitmap_allocator #(
    parameter int NUM_FRAMES = pfba_pkg::PFBA_NUM_FRAMES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pfba_pkg::t_req                    i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pfba_pkg::t_rsp                    o_out_item,
    input  logic                              i_cfg_we,
    input  logic [pfba_pkg::COUNT_W-1:0]      i_cfg_data
);

    import pfba_pkg::*;

    // Words of the bitmap; no item can reach beyond the 2047th frame, so cap at 64 words.
    localparam int WORDS_FULL = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH      = (WORDS_FULL > 64) ? 64 : WORDS_FULL;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_W-1:0] FRAME_CAP =
        COUNT_W'((NUM_FRAMES > 2047) ? 2047 : NUM_FRAMES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [WORD_BITS-1:0] ONES    = '1;
    localparam logic [WORD_BITS-1:0] TOP_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [1:0]           r_state, n_state;
    logic [COUNT_W-1:0]   r_total;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [1:0]           r_op, n_op;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [AW-1:0]        r_word, n_word;
    logic [AW-1:0]        r_last, n_last;
    logic [1:0]           r_status, n_status;
    logic [PAGE_W-1:0]    r_found, n_found;
    logic [DEPTH-1:0]     r_valid, n_valid;
    logic [AW-1:0]        r_raddr;
    logic                 r_out_valid, n_out_valid;
    t_rsp                 r_out, n_out;

    logic [COUNT_W-1:0]   limit;
    logic [COUNT_W-1:0]   limit_m1;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] page_mask;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] avail;
    logic [4:0]           free_idx;

    // Effective frame total: clamp the register to what the bitmap holds.
    assign limit    = (r_total > FRAME_CAP) ? FRAME_CAP : r_total;
    assign limit_m1 = limit - COUNT_W'(1);

    pfba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // A word never written since reset reads as all free.
    assign word = r_valid[r_raddr] ? ram_rdata : '0;

    assign page_mask = TOP_BIT >> r_page[4:0];

    // In the last word, treat frames at or past the limit as taken.
    always_comb begin
        range_mask = ONES;
        if (r_word == r_last && limit[4:0] != 5'd0) begin
            range_mask = ~(ONES >> limit[4:0]);
        end
    end

    assign avail    = ~word & range_mask;
    assign free_idx = first_free(avail);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_page      = r_page;
        n_word      = r_word;
        n_last      = r_last;
        n_status    = r_status;
        n_found     = r_found;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_addr     = r_word;
        wr_en       = 1'b0;
        wr_addr     = r_word;
        wr_data     = word;

        // Drop the result once the sink takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                rd_addr = AW'(i_in_item.page >> 5);
                if (i_in_valid) begin
                    n_op     = i_in_item.opcode;
                    n_page   = i_in_item.page;
                    n_status = ST_OK;
                    n_found  = '0;
                    n_word   = '0;
                    n_last   = AW'(limit_m1 >> 5);
                    case (i_in_item.opcode)
                        OP_MARK, OP_FREE: begin
                            if ({1'b0, i_in_item.page} >= limit) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_word  = AW'(i_in_item.page >> 5);
                                n_state = S_MOD;
                            end
                        end
                        OP_ALLOC: begin
                            rd_addr = '0;
                            if (limit == '0) begin
                                n_status = ST_NOMEM;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MOD: begin
                wr_en            = 1'b1;
                n_valid[r_word]  = 1'b1;
                if (r_op == OP_MARK) begin
                    wr_data = word | page_mask;
                    if (r_count < FRAME_CAP) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end else begin
                    wr_data = word & ~page_mask;
                    if (r_count != '0) begin
                        n_count = r_count - COUNT_W'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // Advance the read one word ahead while this word is checked.
                rd_addr = r_word + AW'(1);
                if (avail != '0) begin
                    wr_en           = 1'b1;
                    wr_data         = word | (TOP_BIT >> free_idx);
                    n_valid[r_word] = 1'b1;
                    n_found         = PAGE_W'({r_word, free_idx});
                    if (r_count < FRAME_CAP) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    n_state = S_DONE;
                end else if (r_word == r_last) begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    n_word = r_word + AW'(1);
                end
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = r_status;
                    n_out.page_out   = r_found;
                    n_out.used_count = r_count;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= COUNT_W'(1024);
            r_count     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_page   <= n_page;
        r_word   <= n_word;
        r_last   <= n_last;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
        r_raddr  <= rd_addr;
    end

endmodule

// ----- rtl/pfba_checker.sv -----
module pfba_checker #(
    parameter int NUM_FRAMES = pfba_pkg::PFBA_NUM_FRAMES
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input pfba_pkg::t_rsp               o_out_item
);

    import pfba_pkg::*;

    localparam logic [COUNT_W-1:0] FRAME_CAP =
        COUNT_W'((NUM_FRAMES > 2047) ? 2047 : NUM_FRAMES);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Take one item at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while busy");

    // Only a successful allocate names a frame.
    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.page_out == '0)
        else $error("page_out set on failure");

    // Keep the count within the frame capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.used_count <= FRAME_CAP)
        else $error("used count past capacity");

    // Drop any result on reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind page_frame_bitmap_allocator pfba_checker #(.NUM_FRAMES(NUM_FRAMES)) u_pfba_checker (.*);

// ----- test/page_frame_bitmap_allocator_tb.sv -----
`timescale 1ns / 100ps

module page_frame_bitmap_allocator_tb;

    import pfba_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 10;
    localparam int FRAMES = PFBA_NUM_FRAMES;
    localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int COUNT_CAP = (FRAMES < 2047) ? FRAMES : 2047;
    // Longest scan is one word per cycle plus read and write-back overhead.
    localparam int SETTLE_CYCLES = MAP_WORDS + 8;
    localparam int IDLE_PCT = 36;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER = 100;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX = 10;

    // Opcode with no action; the package names only the three real ones.
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_req               req;
        t_rsp               rsp;
        logic [COUNT_W-1:0] total;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_req               i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_rsp               o_out_item;
    logic               i_cfg_we = 1'b0;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    // Shadow copy of the allocator state.
    logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
    logic [COUNT_W-1:0]   used_frames = '0;
    logic [COUNT_W-1:0]   total_setting = COUNT_W'(FRAMES);

    t_rsp      pending_rsp [$];
    t_plan_row plan [$];

    int unsigned fail_count = 0;
    int unsigned checked_count = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    bit          hold_done = 1'b0;
    bit          no_idle = 1'b0;

    page_frame_bitmap_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Effective number of frames: clamp the register to the frames present.
    function automatic int frame_limit();
        return (int'(total_setting) > FRAMES) ? FRAMES : int'(total_setting);
    endfunction

    // Apply one request to the shadow state and return the response it produces.
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        int   lim;
        int   pg;
        int   p;
        bit   hit;
        rsp = '0;
        lim = frame_limit();
        pg  = int'(req.page);
        hit = 1'b0;
        case (req.opcode)
            OP_MARK, OP_FREE: begin
                if (pg >= lim) begin
                    rsp.status = ST_RANGE;
                end else if (req.opcode == OP_MARK) begin
                    frame_map[pg / WORD_BITS][WORD_BITS - 1 - pg % WORD_BITS] = 1'b1;
                    if (int'(used_frames) < COUNT_CAP) used_frames = used_frames + COUNT_W'(1);
                end else begin
                    frame_map[pg / WORD_BITS][WORD_BITS - 1 - pg % WORD_BITS] = 1'b0;
                    if (used_frames != '0) used_frames = used_frames - COUNT_W'(1);
                end
            end
            OP_ALLOC: begin
                // First fit: lowest clear frame below the limit, MSB-first in a word.
                for (p = 0; p < lim && !hit; p++) begin
                    if (!frame_map[p / WORD_BITS][WORD_BITS - 1 - p % WORD_BITS]) begin
                        frame_map[p / WORD_BITS][WORD_BITS - 1 - p % WORD_BITS] = 1'b1;
                        if (int'(used_frames) < COUNT_CAP) begin
                            used_frames = used_frames + COUNT_W'(1);
                        end
                        rsp.page_out = PAGE_W'(p);
                        hit = 1'b1;
                    end
                end
                if (!hit) rsp.status = ST_NOMEM;
            end
            default: begin
            end
        endcase
        rsp.used_count = used_frames;
        return rsp;
    endfunction

    function automatic t_plan_row item_row(input logic [1:0] op, input int pg,
                                           input logic [1:0] st, input int pout,
                                           input int cnt);
        t_plan_row row;
        row.kind           = ROW_ITEM;
        row.req.opcode     = op;
        row.req.page       = PAGE_W'(pg);
        row.rsp.status     = st;
        row.rsp.page_out   = PAGE_W'(pout);
        row.rsp.used_count = COUNT_W'(cnt);
        row.total          = '0;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(input int value);
        t_plan_row row;
        row.kind  = ROW_CFG;
        row.req   = '0;
        row.rsp   = '0;
        row.total = COUNT_W'(value);
        return row;
    endfunction

    // Draw a request: opcode by weight (the remainder goes to the unused
    // opcode), mark and free pages mostly inside the frame limit, some beyond it.
    function automatic t_req random_request(input int w_alloc, input int w_mark,
                                            input int w_free);
        t_req req;
        int   roll;
        int   lim;
        roll = $urandom_range(99);
        lim  = frame_limit();
        if (roll < w_alloc) begin
            req.opcode = OP_ALLOC;
        end else if (roll < w_alloc + w_mark) begin
            req.opcode = OP_MARK;
        end else if (roll < w_alloc + w_mark + w_free) begin
            req.opcode = OP_FREE;
        end else begin
            req.opcode = OP_NONE;
        end
        if (req.opcode == OP_ALLOC || req.opcode == OP_NONE) begin
            req.page = PAGE_W'($urandom_range(FRAMES - 1));
        end else if (lim == 0 || (lim < FRAMES && $urandom_range(99) < 12)) begin
            req.page = PAGE_W'($urandom_range(FRAMES - 1, lim));
        end else begin
            req.page = PAGE_W'($urandom_range(lim - 1));
        end
        return req;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("%s", what);
    endtask

    // Offer one item after a random gap, hold it until accepted, then queue
    // the response it must produce. Valid is left high so back-to-back items
    // follow without a gap.
    task automatic send_item(input t_req req, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_request(req);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    // Drain the block, let any scan finish, then write the frame total.
    task automatic write_total(input logic [COUNT_W-1:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        total_setting = value;
    endtask

    task automatic run_phase(input int total, input int count, input int w_alloc,
                             input int w_mark, input int w_free, input bit quiet_stretch);
        write_total(COUNT_W'(total));
        for (int k = 0; k < count; k++) begin
            // Drop all idling on both sides for a stretch of the phase.
            no_idle <= quiet_stretch && k >= 300 && k < 600;
            send_item(random_request(w_alloc, w_mark, w_free), 1'b0, '0);
        end
        no_idle <= 1'b0;
    endtask

    // Response side: random back-pressure, one long hold once the first
    // hundred results are in, and the check against the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                checked_count++;
                if (pending_rsp.size() == 0) begin
                    note_failure($sformatf("unexpected result status=%0d page=%0d count=%0d",
                                           o_out_item.status, o_out_item.page_out,
                                           o_out_item.used_count));
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_out_item.status !== want.status
                            || o_out_item.page_out !== want.page_out
                            || o_out_item.used_count !== want.used_count) begin
                        note_failure($sformatf(
                            "result %0d: expected status=%0d page=%0d count=%0d, got %0d %0d %0d",
                            checked_count, want.status, want.page_out, want.used_count,
                            o_out_item.status, o_out_item.page_out, o_out_item.used_count));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && checked_count >= HOLD_AFTER) begin
                // Hold off long enough that the block backs up and stalls its input.
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("page_frame_bitmap_allocator_tb failed");
        $finish;
    end

    initial begin
        foreach (frame_map[w]) frame_map[w] = '0;

        // Directed plan; every response here can be worked out by hand.
        // Full frame total after reset: first fit, repeated mark and free.
        plan.push_back(item_row(OP_ALLOC, 0,    ST_OK,    0, 1));
        plan.push_back(item_row(OP_ALLOC, 0,    ST_OK,    1, 2));
        plan.push_back(item_row(OP_MARK,  1023, ST_OK,    0, 3));
        // Mark of a used frame still counts up.
        plan.push_back(item_row(OP_MARK,  1023, ST_OK,    0, 4));
        plan.push_back(item_row(OP_FREE,  1023, ST_OK,    0, 3));
        // Free of a free frame still counts down.
        plan.push_back(item_row(OP_FREE,  1023, ST_OK,    0, 2));
        plan.push_back(item_row(OP_FREE,  0,    ST_OK,    0, 1));
        plan.push_back(item_row(OP_ALLOC, 0,    ST_OK,    0, 2));
        // Unused opcode does nothing.
        plan.push_back(item_row(OP_NONE,  1023, ST_OK,    0, 2));
        plan.push_back(item_row(OP_FREE,  1,    ST_OK,    0, 1));
        plan.push_back(item_row(OP_FREE,  0,    ST_OK,    0, 0));
        // Count floors at zero.
        plan.push_back(item_row(OP_FREE,  5,    ST_OK,    0, 0));
        // No frames at all.
        plan.push_back(cfg_row(0));
        plan.push_back(item_row(OP_MARK,  0,    ST_RANGE, 0, 0));
        plan.push_back(item_row(OP_FREE,  0,    ST_RANGE, 0, 0));
        plan.push_back(item_row(OP_ALLOC, 0,    ST_NOMEM, 0, 0));
        // Single frame: allocate it, then run out; page at the total is rejected.
        plan.push_back(cfg_row(1));
        plan.push_back(item_row(OP_ALLOC, 0,    ST_OK,    0, 1));
        plan.push_back(item_row(OP_ALLOC, 0,    ST_NOMEM, 0, 1));
        plan.push_back(item_row(OP_MARK,  1,    ST_RANGE, 0, 1));
        // Oversized total clamps to the frames present.
        plan.push_back(cfg_row(2047));
        plan.push_back(item_row(OP_MARK,  1023, ST_OK,    0, 2));
        plan.push_back(item_row(OP_ALLOC, 0,    ST_OK,    1, 3));
        // Total just past a word boundary.
        plan.push_back(cfg_row(33));
        plan.push_back(item_row(OP_MARK,  32,   ST_OK,    0, 4));
        plan.push_back(item_row(OP_MARK,  33,   ST_RANGE, 0, 4));
        plan.push_back(item_row(OP_ALLOC, 0,    ST_OK,    2, 5));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                write_total(plan[i].total);
            end else begin
                send_item(plan[i].req, 1'b1, plan[i].rsp);
            end
        end

        // Random phases: mixed traffic at full size, a small total that fills
        // and crosses a full word, empty and single-frame totals, a total of 100,
        // then a long fill at the clamped total that drives the count to its ceiling.
        run_phase(FRAMES, 200,  35, 25, 35, 1'b0);
        run_phase(40,     200,  50, 20, 25, 1'b0);
        run_phase(0,      20,   40, 30, 25, 1'b0);
        run_phase(1,      30,   40, 30, 25, 1'b0);
        run_phase(100,    100,  35, 25, 35, 1'b0);
        run_phase(2047,   1150, 55, 42, 2,  1'b1);

        // Drop valid, wait out every response and any trailing activity.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            note_failure($sformatf("%0d responses never arrived", pending_rsp.size()));
        end

        if (fail_count == 0) begin
            $display("page_frame_bitmap_allocator_tb passed");
        end else begin
            $display("page_frame_bitmap_allocator_tb failed");
        end
        $finish;
    end

endmodule
